// ===== src/tcce_pkg.sv =====
// Shared types and constants of the text console character engine.
`default_nettype none

package tcce_pkg;

    // Input selector carried on the slave tuser bit.
    localparam logic CMD_PUT  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Character codes that steer the cursor or bound the printable range.
    localparam logic [7:0] CODE_TAB      = 8'h09;
    localparam logic [7:0] CODE_LF       = 8'h0A;
    localparam logic [7:0] CODE_CR       = 8'h0D;
    localparam logic [7:0] CODE_PRINT_LO = 8'h20;
    localparam logic [7:0] CODE_PRINT_HI = 8'h7E;
    localparam logic [7:0] CODE_QUESTION = 8'h3F;

    // Cell contents: attribute in the high byte, character in the low byte.
    localparam logic [15:0] ATTR_NORMAL = 16'h0700;
    localparam logic [15:0] BLANK_CELL  = 16'h0720;

    // Command queue between the front and back parts.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPW         = $clog2(QUEUE_DEPTH);
    localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

    // Work kinds decided by the front part.
    typedef enum logic [2:0] {
        OP_READ,
        OP_WRITE,
        OP_LF,
        OP_CR,
        OP_TAB
    } op_kind_t;

    // One queued command.
    typedef struct packed {
        op_kind_t    kind;
        logic [7:0]  char_code;
        logic [9:0]  cell_index;
    } op_t;

    // Status reported by the back part to the front part.
    typedef struct packed {
        logic clearing;
    } back_status_t;

    // Sequencer states of the back part.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_MUL,
        ST_CHECK,
        ST_COPY,
        ST_FILL,
        ST_DONE
    } back_state_t;

endpackage

`default_nettype wire

// ===== src/tcce_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module tcce_ram #(
    parameter  int WIDTH = 16,
    parameter  int DEPTH = 1000,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== src/tcce_front.sv =====
// Front part: accepts input beats, classifies them and queues the commands.
`default_nettype none

module tcce_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [23:0]           s_axis_tdata,  // char_code[7:0], cell_index[17:8]
    input  wire logic                  s_axis_tuser,  // command[0]
    input  wire tcce_pkg::back_status_t status,
    output logic                       op_valid,
    input  wire logic                  op_ready,
    output tcce_pkg::op_t              op
);

    import tcce_pkg::*;

    op_t            in_op;
    logic [7:0]     code;
    logic           push;
    logic           pop;
    op_t            ent_reg [QUEUE_DEPTH];
    logic [QPW-1:0] wr_ptr_reg;
    logic [QPW-1:0] wr_ptr_next;
    logic [QPW-1:0] rd_ptr_reg;
    logic [QPW-1:0] rd_ptr_next;
    logic [QCW-1:0] count_reg;
    logic [QCW-1:0] count_next;

    assign code = s_axis_tdata[7:0];

    // Classify the beat; unprintable puts other than LF, CR, TAB become '?'.
    always_comb
    begin
        in_op.cell_index = s_axis_tdata[17:8];
        in_op.char_code  = code;
        if (s_axis_tuser == CMD_READ)
        begin
            in_op.kind = OP_READ;
        end
        else if (code == CODE_LF)
        begin
            in_op.kind = OP_LF;
        end
        else if (code == CODE_CR)
        begin
            in_op.kind = OP_CR;
        end
        else if (code == CODE_TAB)
        begin
            in_op.kind = OP_TAB;
        end
        else
        begin
            in_op.kind = OP_WRITE;
            if (code < CODE_PRINT_LO || code > CODE_PRINT_HI)
            begin
                in_op.char_code = CODE_QUESTION;
            end
        end
    end

    // Handshakes on both sides of the queue.
    assign s_axis_tready = !status.clearing && (count_reg != QCW'(QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign op_valid      = (count_reg != '0);
    assign pop           = op_valid && op_ready;
    assign op            = ent_reg[rd_ptr_reg];

    // Pointer and fill count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Queue control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wr_ptr_reg] <= in_op;
        end
    end

endmodule

`default_nettype wire

// ===== src/tcce_back.sv =====
// Back part: sequencer that carries out queued commands on the screen store.
`default_nettype none

module tcce_back #(
    parameter  int COLUMNS   = 40,
    parameter  int ROWS      = 25,
    parameter  int TAB_WIDTH = 8,
    localparam int AW        = $clog2(COLUMNS * ROWS)
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   op_valid,
    output logic                        op_ready,
    input  wire tcce_pkg::op_t          op,
    output tcce_pkg::back_status_t      status,
    output logic                        wr_en,
    output logic [AW-1:0]               wr_addr,
    output logic [15:0]                 wr_data,
    output logic [AW-1:0]               rd_addr,
    input  wire logic [15:0]            rd_data,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [31:0]                 m_axis_tdata,  // cell_data[15:0], cursor[25:16]
    output logic                        m_axis_tuser   // scrolled[0]
);

    import tcce_pkg::*;

    localparam int CELL_TOTAL = COLUMNS * ROWS;
    localparam int CW         = $clog2(CELL_TOTAL + COLUMNS + TAB_WIDTH);
    localparam int DMAX       = (COLUMNS > TAB_WIDTH) ? COLUMNS : TAB_WIDTH;
    // Reciprocal scaling, exact for every dividend below 2**AW.
    localparam int DS         = AW + $clog2(DMAX);
    localparam int MC         = ((2 ** DS) + COLUMNS - 1) / COLUMNS;
    localparam int MT         = ((2 ** DS) + TAB_WIDTH - 1) / TAB_WIDTH;

    localparam logic [AW-1:0] LAST_CELL = AW'(CELL_TOTAL - 1);
    localparam logic [AW-1:0] SHIFT_END = AW'(CELL_TOTAL - COLUMNS);
    localparam logic [CW-1:0] TOTAL_CW  = CW'(CELL_TOTAL);

    back_state_t      state_reg;
    back_state_t      state_next;
    logic [CW-1:0]    cursor_reg;
    logic [CW-1:0]    cursor_next;
    logic [AW-1:0]    ptr_reg;
    logic [AW-1:0]    ptr_next;
    logic             pend_valid_reg;
    logic             pend_valid_next;
    logic [AW-1:0]    pend_addr_reg;
    logic [AW-1:0]    pend_addr_next;
    op_t              op_reg;
    op_t              op_next;
    logic [AW-1:0]    quo_reg;
    logic [AW-1:0]    quo_next;
    logic [15:0]      data_reg;
    logic [15:0]      data_next;
    logic             scrolled_reg;
    logic             scrolled_next;
    logic             in_range_reg;
    logic             in_range_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [15:0]      out_cell_reg;
    logic [9:0]       out_cursor_reg;
    logic             out_scrolled_reg;
    logic             load_out;
    logic [DS-1:0]    mul_k;
    logic [AW+DS-1:0] prod;

    // Division of the cursor by the row length or the tab width.
    always_comb
    begin
        mul_k = (op_reg.kind == OP_CR) ? DS'(MC) : DS'(MT);
        prod  = (AW + DS)'(cursor_reg[AW-1:0]) * (AW + DS)'(mul_k);
    end

    // Sequencer next state and store port control.
    always_comb
    begin
        state_next      = state_reg;
        cursor_next     = cursor_reg;
        ptr_next        = ptr_reg;
        pend_valid_next = pend_valid_reg;
        pend_addr_next  = pend_addr_reg;
        op_next         = op_reg;
        quo_next        = quo_reg;
        data_next       = data_reg;
        scrolled_next   = scrolled_reg;
        in_range_next   = in_range_reg;
        op_ready        = 1'b0;
        wr_en           = 1'b0;
        wr_addr         = ptr_reg;
        wr_data         = BLANK_CELL;
        rd_addr         = ptr_reg;
        load_out        = 1'b0;

        case (state_reg)
            ST_CLEAR:
            begin
                wr_en    = 1'b1;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == LAST_CELL)
                begin
                    ptr_next   = '0;
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (op_valid)
                begin
                    op_ready      = 1'b1;
                    op_next       = op;
                    data_next     = '0;
                    scrolled_next = 1'b0;
                    in_range_next = (int'(op.cell_index) < CELL_TOTAL);
                    rd_addr       = AW'(op.cell_index);
                    case (op.kind)
                        OP_READ:
                        begin
                            state_next = ST_READ;
                        end
                        OP_WRITE:
                        begin
                            wr_en       = (cursor_reg < TOTAL_CW);
                            wr_addr     = AW'(cursor_reg);
                            wr_data     = ATTR_NORMAL | {8'h00, op.char_code};
                            cursor_next = cursor_reg + 1'b1;
                            state_next  = ST_CHECK;
                        end
                        OP_LF:
                        begin
                            cursor_next = cursor_reg + CW'(COLUMNS);
                            state_next  = ST_CHECK;
                        end
                        OP_CR, OP_TAB:
                        begin
                            state_next = ST_DIV;
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                // Cells past the end of the screen read as zero.
                data_next  = in_range_reg ? rd_data : '0;
                state_next = ST_DONE;
            end

            ST_DIV:
            begin
                quo_next   = prod[AW+DS-1:DS];
                state_next = ST_MUL;
            end

            ST_MUL:
            begin
                if (op_reg.kind == OP_CR)
                begin
                    cursor_next = CW'(quo_reg * COLUMNS);
                end
                else
                begin
                    cursor_next = CW'((quo_reg + 1) * TAB_WIDTH);
                end
                state_next = ST_CHECK;
            end

            ST_CHECK:
            begin
                if (cursor_reg >= TOTAL_CW)
                begin
                    cursor_next     = cursor_reg - CW'(COLUMNS);
                    scrolled_next   = 1'b1;
                    ptr_next        = '0;
                    pend_valid_next = 1'b0;
                    state_next      = ST_COPY;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end

            ST_COPY:
            begin
                // Read one row ahead and write the cell fetched last cycle.
                if (ptr_reg != SHIFT_END)
                begin
                    rd_addr  = AW'(ptr_reg + COLUMNS);
                    ptr_next = ptr_reg + 1'b1;
                end
                pend_valid_next = (ptr_reg != SHIFT_END);
                pend_addr_next  = ptr_reg;
                if (pend_valid_reg)
                begin
                    wr_en   = 1'b1;
                    wr_addr = pend_addr_reg;
                    wr_data = rd_data;
                end
                if (ptr_reg == SHIFT_END && pend_valid_reg)
                begin
                    state_next = ST_FILL;
                end
            end

            ST_FILL:
            begin
                wr_en    = 1'b1;
                ptr_next = ptr_reg + 1'b1;
                if (ptr_reg == LAST_CELL)
                begin
                    ptr_next   = '0;
                    state_next = ST_CHECK;
                end
            end

            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output beat register.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            cursor_reg     <= '0;
            ptr_reg        <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cursor_reg     <= cursor_next;
            ptr_reg        <= ptr_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        op_reg        <= op_next;
        quo_reg       <= quo_next;
        data_reg      <= data_next;
        scrolled_reg  <= scrolled_next;
        in_range_reg  <= in_range_next;
        if (load_out)
        begin
            out_cell_reg     <= data_reg;
            out_cursor_reg   <= 10'(cursor_reg);
            out_scrolled_reg <= scrolled_reg;
        end
    end

    assign status.clearing = (state_reg == ST_CLEAR);
    assign m_axis_tvalid   = out_valid_reg;
    assign m_axis_tdata    = {6'b000000, out_cursor_reg, out_cell_reg};
    assign m_axis_tuser    = out_scrolled_reg;

endmodule

`default_nettype wire

// ===== src/text_console_character_engine_top.sv =====
// Top level of the text console character engine.
`default_nettype none

// A screen of ROWS x COLUMNS 16-bit cells (attribute high byte, character low
// byte) with a linear cursor. A put beat writes a character with attribute
// 0x07 at the cursor, or moves the cursor for LF, CR and TAB; a read beat
// returns one cell. Every input beat yields exactly one output beat carrying
// the cell data (zero for puts), the cursor and a scrolled flag. After reset
// the block clears all COLUMNS*ROWS cells (1000 by default), one cell a
// cycle, taking no input beat meanwhile. A sequencer over one store port pair
// does the work: a read goes through READ and DONE, a printable character or
// LF through CHECK and DONE, CR and TAB through DIV, MUL, CHECK and DONE
// (they divide the cursor by a two-step reciprocal multiply). A put that runs
// off the end of the screen scrolls it a row at a time: the rows are copied
// up one cell a cycle and the bottom row is blanked. A two-entry command
// queue and an output register let input and output stall independently.
module text_console_character_engine_top #(
    parameter int COLUMNS   = 40,
    parameter int ROWS      = 25,
    parameter int TAB_WIDTH = 8
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // char_code[7:0], cell_index[17:8]
    input  wire logic        s_axis_tuser,   // command[0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // cell_data[15:0], cursor[25:16]
    output logic             m_axis_tuser    // scrolled[0]
);

    import tcce_pkg::*;

    localparam int CELL_TOTAL = COLUMNS * ROWS;
    localparam int AW         = $clog2(CELL_TOTAL);

    back_status_t  status;
    logic          op_valid;
    logic          op_ready;
    op_t           op;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic [AW-1:0] rd_addr;
    logic [15:0]   rd_data;

    // Beat intake, classification and command queue.
    tcce_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .status        (status),
        .op_valid      (op_valid),
        .op_ready      (op_ready),
        .op            (op)
    );

    // Command execution and output register.
    tcce_back #(
        .COLUMNS   (COLUMNS),
        .ROWS      (ROWS),
        .TAB_WIDTH (TAB_WIDTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .op_valid      (op_valid),
        .op_ready      (op_ready),
        .op            (op),
        .status        (status),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data),
        .rd_addr       (rd_addr),
        .rd_data       (rd_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Screen store.
    tcce_ram #(
        .WIDTH (16),
        .DEPTH (CELL_TOTAL)
    ) u_screen (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

`default_nettype wire

// ===== src/tcce_checker.sv =====
// Port-level checker for the text console character engine, with its bind.
`default_nettype none

module tcce_checker #(
    parameter int COLUMNS = 40,
    parameter int ROWS    = 25
) (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [31:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);

    localparam int CELL_TOTAL = COLUMNS * ROWS;

    logic       in_beat;
    logic       out_beat;
    logic [2:0] outstanding_reg;
    logic [2:0] outstanding_next;

    assign in_beat  = s_axis_tvalid && s_axis_tready;
    assign out_beat = m_axis_tvalid && m_axis_tready;

    // Beats taken in but not yet delivered.
    always_comb
    begin
        outstanding_next = outstanding_reg;
        if (in_beat && !out_beat)
        begin
            outstanding_next = outstanding_reg + 1'b1;
        end
        else if (out_beat && !in_beat)
        begin
            outstanding_next = outstanding_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outstanding_reg <= '0;
        end
        else
        begin
            outstanding_reg <= outstanding_next;
        end
    end

    // No result is offered without an input beat behind it.
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> outstanding_reg != 3'd0)
        else $error("result offered with no input beat outstanding");

    // A scrolling put carries zero cell data.
    a_scroll_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[15:0] == 16'h0000)
        else $error("scrolled result carries cell data");

    // The reported cursor stays on the screen (checked for up to 1024 cells).
    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (CELL_TOTAL > 1024) || (int'(m_axis_tdata[25:16]) < CELL_TOTAL))
        else $error("cursor beyond the last cell");

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result beat changed");

endmodule

bind text_console_character_engine_top tcce_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_checker (.*);

`default_nettype wire
